// File: hw/rtl/pcpg_pkg.sv
package pcpg_pkg;

    localparam int QUO_W         = 16;
    localparam int NUM_W         = 15;
    localparam int OFFS_W        = 9;
    localparam int DIV_CNT_W     = $clog2(NUM_W);
    localparam int LID_W         = 16;
    localparam int LUM_W         = 6;

    localparam logic [9:0]        HORIZON         = 10'd240;
    localparam logic [9:0]        CEIL_BASE       = 10'd272;
    localparam logic [9:0]        FLOOR_BASE      = 10'd208;
    localparam logic [OFFS_W-1:0] BAND_LOW        = 9'd35;
    localparam logic [OFFS_W-1:0] BAND_HIGH       = 9'd200;
    localparam logic [9:0]        VISIBLE_W       = 10'd640;
    localparam logic [15:0]       CENTER_X        = 16'd320;
    localparam logic [6:0]        FOG_BASE        = 7'd70;
    localparam logic [6:0]        LUM_MAX         = 7'd63;
    localparam logic [15:0]       SCROLL_U_STEP   = 16'd1024;
    localparam logic [NUM_W-1:0]  NUMERATOR_RESET = 15'd22000;

endpackage

// File: hw/rtl/perspective_checker_plane_pixel_gen.sv
// Perspective checkerboard floor/ceiling pixel generator. One pixel transfer
// (x, y, vertical blank) is accepted per clock and gives one RGB transfer in
// the next cycle through an output register, so the stream runs at one pixel
// per cycle while no stall holds the input. The first pixel (x == 0) of each
// visible band row latches the inverse depth of the previous band row, sets
// the fog level and starts a bit-serial restoring divider (depth_numerator /
// row offset) that produces one quotient bit per cycle. A further row-start
// pixel arriving while that divider is still running is stalled until it
// finishes; others wait only on i_out_stall. depth_numerator may be written
// only while the block is idle; it is captured when a division starts.
module perspective_checker_plane_pixel_gen (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_depth_numerator_we,
    input  logic [pcpg_pkg::NUM_W-1:0]   i_depth_numerator,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [9:0]                   i_pixel_x,
    input  logic [9:0]                   i_pixel_y,
    input  logic                         i_vertical_blank,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [7:0]                   o_red,
    output logic [7:0]                   o_green,
    output logic [7:0]                   o_blue
);

    localparam int NW = pcpg_pkg::NUM_W;
    localparam int OW = pcpg_pkg::OFFS_W;
    localparam int CW = pcpg_pkg::DIV_CNT_W;
    localparam int LW = pcpg_pkg::LID_W;
    localparam int FW = pcpg_pkg::LUM_W;
    localparam int QW = pcpg_pkg::QUO_W;

    // configuration and frame state
    logic [NW-1:0]                   r_numerator;
    logic [QW-1:0]                   r_div_result, n_div_result;
    logic [LW-1:0]                   r_lid, n_lid;
    logic [FW-1:0]                   r_fog, n_fog;
    logic [15:0]                     r_scroll_u, n_scroll_u;
    logic [7:0]                      r_scroll_v, n_scroll_v;
    logic                            r_blank_seen, n_blank_seen;

    // bit-serial divider
    logic                            r_busy, n_busy;
    logic [CW-1:0]                   r_div_cnt, n_div_cnt;
    logic [NW-1:0]                   r_div_quo, n_div_quo;
    logic [OW-1:0]                   r_div_rem, n_div_rem;
    logic [OW-1:0]                   r_div_den, n_div_den;

    // output register
    logic                            r_out_valid, n_out_valid;
    logic [7:0]                      r_red, r_green, r_blue;
    logic [7:0]                      n_red, n_green, n_blue;

    logic                            w_in_acc;
    logic                            w_out_acc;
    logic [9:0]                      w_offs_full;
    logic [OW-1:0]                   w_offs;
    logic                            w_is_floor;
    logic                            w_in_band;
    logic                            w_line_start;
    logic [6:0]                      w_fog_bits;
    logic [6:0]                      w_fog_raw;
    logic [15:0]                     w_dx;
    logic [15:0]                     w_prod;
    logic [15:0]                     w_usum;
    logic [7:0]                      w_u;
    logic [7:0]                      w_v;
    logic [7:0]                      w_t;
    logic [7:0]                      w_lum1;
    logic [7:0]                      w_lum2;
    logic [OW:0]                     w_rem_sh;
    logic                            w_ge;

    // band and row offset
    always_comb begin
        w_is_floor = (i_pixel_y >= pcpg_pkg::HORIZON);
        if (w_is_floor) begin
            w_offs_full = i_pixel_y - pcpg_pkg::FLOOR_BASE;
        end else begin
            w_offs_full = pcpg_pkg::CEIL_BASE - i_pixel_y;
        end
        w_offs    = w_offs_full[OW-1:0];
        w_in_band = !i_vertical_blank && (i_pixel_x < pcpg_pkg::VISIBLE_W)
                    && (w_offs >= pcpg_pkg::BAND_LOW) && (w_offs < pcpg_pkg::BAND_HIGH);
        w_line_start = w_in_band && (i_pixel_x == 10'd0);
    end

    assign o_in_stall = (r_out_valid && i_out_stall) || (r_busy && w_line_start);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_acc  = r_out_valid && !i_out_stall;

    // divider step
    always_comb begin
        w_rem_sh = {r_div_rem, r_div_quo[NW-1]};
        w_ge     = (w_rem_sh >= {1'b0, r_div_den});
    end

    // pixel datapath and state update
    always_comb begin
        n_div_result = r_div_result;
        n_lid        = r_lid;
        n_fog        = r_fog;
        n_scroll_u   = r_scroll_u;
        n_scroll_v   = r_scroll_v;
        n_blank_seen = r_blank_seen;
        n_busy       = r_busy;
        n_div_cnt    = r_div_cnt;
        n_div_quo    = r_div_quo;
        n_div_rem    = r_div_rem;
        n_div_den    = r_div_den;
        n_out_valid  = r_out_valid && !w_out_acc;
        n_red        = r_red;
        n_green      = r_green;
        n_blue       = r_blue;
        w_fog_bits   = '0;
        w_fog_raw    = '0;

        if (r_busy) begin
            n_div_quo = {r_div_quo[NW-2:0], w_ge};
            if (w_ge) begin
                n_div_rem = OW'(w_rem_sh - {1'b0, r_div_den});
            end else begin
                n_div_rem = w_rem_sh[OW-1:0];
            end
            n_div_cnt = r_div_cnt - CW'(1);
            if (r_div_cnt == '0) begin
                n_busy       = 1'b0;
                n_div_result = QW'({r_div_quo[NW-2:0], w_ge});
            end
        end

        if (w_in_acc) begin
            n_blank_seen = i_vertical_blank;
            if (i_vertical_blank && !r_blank_seen) begin
                n_scroll_u = r_scroll_u + pcpg_pkg::SCROLL_U_STEP;
                n_scroll_v = r_scroll_v + 8'd1;
            end
            if (w_line_start) begin
                n_lid      = LW'(r_div_result);
                w_fog_bits = n_lid[9:3];
                if (w_fog_bits <= pcpg_pkg::FOG_BASE) begin
                    w_fog_raw = pcpg_pkg::FOG_BASE - w_fog_bits;
                    if (w_fog_raw > pcpg_pkg::LUM_MAX) begin
                        n_fog = FW'(pcpg_pkg::LUM_MAX);
                    end else begin
                        n_fog = w_fog_raw[FW-1:0];
                    end
                end else begin
                    n_fog = '0;
                end
                n_busy    = 1'b1;
                n_div_cnt = CW'(NW - 1);
                n_div_quo = r_numerator;
                n_div_rem = '0;
                n_div_den = w_offs;
            end
        end

        w_dx   = {6'd0, i_pixel_x} - pcpg_pkg::CENTER_X;
        w_prod = 16'(w_dx * n_lid);
        w_usum = r_scroll_u + w_prod;
        w_u    = w_usum[15:8];
        w_v    = r_scroll_v + {2'd0, n_lid[5:0]};
        w_t    = w_u ^ w_v;
        w_lum1 = {1'b0, n_fog, 1'b0};
        w_lum2 = {n_fog, 2'b00};

        if (w_in_acc) begin
            n_out_valid = 1'b1;
            n_red       = '0;
            n_green     = '0;
            n_blue      = '0;
            if (w_in_band) begin
                if (w_t[5]) begin
                    n_red   = w_t[4] ? w_lum2 : w_lum1;
                    n_green = w_t[4] ? w_lum2 : w_lum1;
                    n_blue  = w_t[4] ? w_lum2 : w_lum1;
                end else if (w_t[4]) begin
                    if (w_is_floor) begin
                        n_red = w_lum2;
                    end else begin
                        n_blue = w_lum2;
                    end
                end else begin
                    if (w_is_floor) begin
                        n_green = w_lum1;
                    end else begin
                        n_blue = w_lum1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_numerator  <= pcpg_pkg::NUMERATOR_RESET;
            r_div_result <= '0;
            r_lid        <= '0;
            r_fog        <= '0;
            r_scroll_u   <= '0;
            r_scroll_v   <= '0;
            r_blank_seen <= 1'b0;
            r_busy       <= 1'b0;
            r_div_cnt    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_depth_numerator_we) begin
                r_numerator <= i_depth_numerator;
            end
            r_div_result <= n_div_result;
            r_lid        <= n_lid;
            r_fog        <= n_fog;
            r_scroll_u   <= n_scroll_u;
            r_scroll_v   <= n_scroll_v;
            r_blank_seen <= n_blank_seen;
            r_busy       <= n_busy;
            r_div_cnt    <= n_div_cnt;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div_quo <= n_div_quo;
        r_div_rem <= n_div_rem;
        r_div_den <= n_div_den;
        r_red     <= n_red;
        r_green   <= n_green;
        r_blue    <= n_blue;
    end

    assign o_out_valid = r_out_valid;
    assign o_red       = r_red;
    assign o_green     = r_green;
    assign o_blue      = r_blue;

    // a row start never overtakes a running division
    a_no_start_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && r_busy) |-> !w_line_start)
        else $error("row start accepted while divider busy");

    // every accepted pixel yields a result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_out_valid)
        else $error("accepted pixel produced no result");

    // partial remainder stays below the divisor while dividing
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_div_rem < r_div_den))
        else $error("divider remainder out of range");

endmodule
